FILE: rtl/p2hc_pkg.sv
// shared types, constants and helpers for the point to hex cell block
`default_nettype none

package p2hc_pkg;

	localparam int DEF_COORD_WIDTH = 32;
	localparam int DEF_INDEX_WIDTH = 24;

	// coordinates are Q.8, reciprocals Q16.16, so products carry 24 fraction bits
	localparam int FRAC_BITS = 24;
	localparam int INV_WIDTH = 32;
	localparam logic [INV_WIDTH-1:0] INV_RESET = 32'h0001_0000;

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_COL_WIDTH  = 1'b0,
		REG_INV_ROW_HEIGHT = 1'b1
	} cfg_reg_t;

	// load enables of the per-axis multiply stages
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} axis_en_t;

	// width of the signed integer part of a scaled coordinate
	function automatic int prod_int_width(input int cw);
		return cw + INV_WIDTH - FRAC_BITS + 2;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/point_to_hex_cell_top.sv
// an item is registered at input, magnitude, partial products, product sum, floor and fraction, cell and output
// throughput: one item per cycle while the output is not stalled, set by the fully pipelined multiply per axis
// each stage holds its item only while the next stage is full and stalled
// reset: stages empty, no origin taken, running minimum 1, reciprocals 1.0
// first item after reset sets the grid origin and yields column 0, row 0
`default_nettype none

module point_to_hex_cell_top import p2hc_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH,
	parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_wen,
	input  logic [CFG_IDX_W-1:0]                     cfg_index,
	input  logic [INV_WIDTH-1:0]                     cfg_wdata,
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	// point_x, point_y
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	// hex_col, hex_row, min_row_seen
	output logic [((3*INDEX_WIDTH+8)/8)*8-1:0]       m_axis_tdata
);

	localparam int CW     = COORD_WIDTH;
	localparam int IW     = INDEX_WIDTH;
	localparam int IPW    = prod_int_width(CW);
	localparam int NSTG   = 7;
	localparam int TDW_O  = ((3*IW+8)/8)*8;

	logic [NSTG:1]          stage_vld_q;
	logic [NSTG+1:1]        rdy;
	logic                   in_acc;
	axis_en_t               en;

	logic [INV_WIDTH-1:0]   inv_col_q;
	logic [INV_WIDTH-1:0]   inv_row_q;
	logic signed [CW-1:0]   origin_x_q;
	logic signed [CW-1:0]   origin_y_q;
	logic                   origin_taken_q;

	logic signed [CW-1:0]   px_s1;
	logic signed [CW-1:0]   py_s1;
	logic                   first_s1;
	logic                   first_s2;
	logic                   first_s3;
	logic                   first_s4;
	logic                   first_s5;
	logic                   first_s6;

	logic signed [IPW-1:0]  cx_s5;
	logic [FRAC_BITS-1:0]   cf_s5;
	logic signed [IPW-1:0]  ry_s5;
	logic [FRAC_BITS-1:0]   rf_s5;
	logic [IW-1:0]          col_c;
	logic [IW-1:0]          row_c;
	logic [IW-1:0]          col_s6;
	logic [IW-1:0]          row_s6;

	logic [IW-1:0]          hex_col_q;
	logic [IW-1:0]          hex_row_q;
	logic signed [IW:0]     lowest_q;
	logic signed [IW:0]     row_ext;
	logic signed [IW:0]     cand;

	// a stage can load when empty or when its item moves on
	always_comb begin
		rdy[NSTG+1] = m_axis_tready;
		for (int k = NSTG; k >= 1; k--)
			rdy[k] = !stage_vld_q[k] || rdy[k+1];
	end

	assign s_axis_tready = rdy[1];
	assign in_acc        = s_axis_tvalid && rdy[1];
	assign en            = '{s2: rdy[2], s3: rdy[3], s4: rdy[4], s5: rdy[5]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (rdy[1])
				stage_vld_q[1] <= s_axis_tvalid;
			for (int k = 2; k <= NSTG; k++)
				if (rdy[k])
					stage_vld_q[k] <= stage_vld_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_col_q <= INV_RESET;
			inv_row_q <= INV_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INV_COL_WIDTH:  inv_col_q <= cfg_wdata;
				REG_INV_ROW_HEIGHT: inv_row_q <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_taken_q <= 1'b0;
		end else if (in_acc) begin
			origin_taken_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && !origin_taken_q) begin
			origin_x_q <= s_axis_tdata[CW-1:0];
			origin_y_q <= s_axis_tdata[2*CW-1:CW];
		end
		if (rdy[1]) begin
			px_s1    <= s_axis_tdata[CW-1:0];
			py_s1    <= s_axis_tdata[2*CW-1:CW];
			first_s1 <= !origin_taken_q;
		end
		if (rdy[2])
			first_s2 <= first_s1;
		if (rdy[3])
			first_s3 <= first_s2;
		if (rdy[4])
			first_s4 <= first_s3;
		if (rdy[5])
			first_s5 <= first_s4;
		if (rdy[6]) begin
			first_s6 <= first_s5;
			col_s6   <= first_s5 ? '0 : col_c;
			row_s6   <= first_s5 ? '0 : row_c;
		end
		if (rdy[7]) begin
			hex_col_q <= col_s6;
			hex_row_q <= row_s6;
		end
	end

	p2hc_axis #(.CW(CW)) u_axis_x (
		.clk      (clk),
		.en       (en),
		.coord_s1 (px_s1),
		.origin   (origin_x_q),
		.inv      (inv_col_q),
		.ip_s5    (cx_s5),
		.fr_s5    (cf_s5)
	);

	p2hc_axis #(.CW(CW)) u_axis_y (
		.clk      (clk),
		.en       (en),
		.coord_s1 (py_s1),
		.origin   (origin_y_q),
		.inv      (inv_row_q),
		.ip_s5    (ry_s5),
		.fr_s5    (rf_s5)
	);

	p2hc_cell #(.CW(CW), .IW(IW)) u_cell (
		.cx  (cx_s5),
		.cf  (cf_s5),
		.ry  (ry_s5),
		.rf  (rf_s5),
		.col (col_c),
		.row (row_c)
	);

	// running minimum of row - 1 over items after the origin item, updated as an item enters the output register
	assign row_ext = {row_s6[IW-1], row_s6};
	assign cand    = row_ext - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q <= (IW+1)'(1);
		end else if (rdy[7] && stage_vld_q[6] && !first_s6 && (cand < lowest_q)) begin
			lowest_q <= cand;
		end
	end

	assign m_axis_tvalid = stage_vld_q[NSTG];
	assign m_axis_tdata  = TDW_O'({lowest_q, hex_row_q, hex_col_q});

	a_origin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(origin_taken_q))
		else $error("origin flag dropped");

	a_min_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (lowest_q <= $past(lowest_q)))
		else $error("running minimum increased");

	a_origin_before_work: assert property (@(posedge clk) disable iff (!arst_n)
		stage_vld_q[1] |-> origin_taken_q)
		else $error("item in pipeline without an origin");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !stage_vld_q[6]) |=> !m_axis_tvalid)
		else $error("result shown with no item behind it");

endmodule

`default_nettype wire

FILE: rtl/p2hc_axis.sv
// one axis: offset from origin, scale by reciprocal, split into floor and fraction
`default_nettype none

module p2hc_axis import p2hc_pkg::*; #(
	parameter int CW = DEF_COORD_WIDTH
) (
	input  logic                              clk,
	input  axis_en_t                          en,
	input  logic signed [CW-1:0]              coord_s1,
	input  logic signed [CW-1:0]              origin,
	input  logic        [INV_WIDTH-1:0]       inv,
	output logic signed [prod_int_width(CW)-1:0] ip_s5,
	output logic        [FRAC_BITS-1:0]       fr_s5
);

	localparam int IPW  = prod_int_width(CW);
	localparam int MW   = CW + 1;
	localparam int LO_W = (MW + 1) / 2;
	localparam int HI_W = MW - LO_W;
	localparam int PW   = MW + INV_WIDTH;

	logic signed [CW:0]              diff;
	logic        [MW-1:0]            mag_c;
	logic        [MW-1:0]            mag_s2;
	logic                            neg_s2;
	logic        [LO_W+INV_WIDTH-1:0] pp_lo_s3;
	logic        [HI_W+INV_WIDTH-1:0] pp_hi_s3;
	logic                            neg_s3;
	logic        [PW-1:0]            prod_c;
	logic        [PW-1:0]            prod_s4;
	logic                            neg_s4;
	logic        [IPW-1:0]           mi_ext;
	logic        [FRAC_BITS-1:0]     mf;
	logic signed [IPW-1:0]           ip_c;
	logic        [FRAC_BITS-1:0]     fr_c;

	assign diff  = {coord_s1[CW-1], coord_s1} - {origin[CW-1], origin};
	assign mag_c = diff[CW] ? (~diff + 1'b1) : diff;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			mag_s2 <= mag_c;
			neg_s2 <= diff[CW];
		end
		if (en.s3) begin
			pp_lo_s3 <= mag_s2[LO_W-1:0] * inv;
			pp_hi_s3 <= mag_s2[MW-1:LO_W] * inv;
			neg_s3   <= neg_s2;
		end
		if (en.s4) begin
			prod_s4 <= prod_c;
			neg_s4  <= neg_s3;
		end
		if (en.s5) begin
			ip_s5 <= ip_c;
			fr_s5 <= fr_c;
		end
	end

	assign prod_c = {pp_hi_s3, {LO_W{1'b0}}} + PW'(pp_lo_s3);

	assign mi_ext = {1'b0, prod_s4[PW-1:FRAC_BITS]};
	assign mf     = prod_s4[FRAC_BITS-1:0];

	// floor of a negative value: -m when exact, -m-1 (= ~m) otherwise
	always_comb begin
		if (!neg_s4) begin
			ip_c = mi_ext;
			fr_c = mf;
		end else begin
			ip_c = (mf == '0) ? (~mi_ext + 1'b1) : ~mi_ext;
			fr_c = ~mf + 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/p2hc_cell.sv
// hexagon edge test on floor/fraction pairs, column and row adjust, saturation
`default_nettype none

module p2hc_cell import p2hc_pkg::*; #(
	parameter int CW = DEF_COORD_WIDTH,
	parameter int IW = DEF_INDEX_WIDTH
) (
	input  logic signed [prod_int_width(CW)-1:0] cx,
	input  logic        [FRAC_BITS-1:0]          cf,
	input  logic signed [prod_int_width(CW)-1:0] ry,
	input  logic        [FRAC_BITS-1:0]          rf,
	output logic        [IW-1:0]                 col,
	output logic        [IW-1:0]                 row
);

	localparam int IPW = prod_int_width(CW);
	localparam int SW  = ((IPW > IW) ? IPW : IW) + 1;
	localparam logic signed [SW-1:0] SAT_HI = {{(SW-IW+1){1'b0}}, {(IW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
	localparam logic [FRAC_BITS+1:0] TWO_ONE = {2'b10, {FRAC_BITS{1'b0}}};

	logic [FRAC_BITS+1:0]   cf3;
	logic                   right_third;
	logic [FRAC_BITS-1:0]   xc;
	logic [FRAC_BITS-1:0]   yr;
	logic                   x_odd;
	logic                   h_odd;
	logic                   step;
	logic                   yinc;
	logic                   ydec;
	logic signed [1:0]      dy;
	logic signed [IPW-1:0]  x_adj;
	logic signed [IPW-1:0]  y_adj;

	function automatic logic [IW-1:0] sat(input logic signed [IPW-1:0] v);
		logic signed [SW-1:0] e;
		e = {{(SW-IPW){v[IPW-1]}}, v};
		if (e > SAT_HI)
			return SAT_HI[IW-1:0];
		else if (e < SAT_LO)
			return SAT_LO[IW-1:0];
		return e[IW-1:0];
	endfunction

	// 3*frac > 2 stands for frac > 2/3
	assign cf3         = {2'b00, cf} + {1'b0, cf, 1'b0};
	assign right_third = cf3 > TWO_ONE;
	assign xc          = FRAC_BITS'(cf3 - TWO_ONE);
	assign yr          = {rf[FRAC_BITS-2:0], 1'b0};
	assign x_odd       = cx[0];
	// parity of the half-row index truncated toward zero
	assign h_odd       = rf[FRAC_BITS-1] ^ (ry[IPW-1] && (yr != '0));

	always_comb begin
		step = 1'b0;
		yinc = 1'b0;
		ydec = 1'b0;
		if (right_third) begin
			if (x_odd == h_odd) begin
				if (xc > yr) begin
					step = 1'b1;
					ydec = !x_odd;
				end
			end else begin
				if (yr > xc) begin
					step = 1'b1;
					yinc = x_odd;
				end
			end
		end
	end

	always_comb begin
		dy = 2'sd0;
		// odd columns sit half a row lower
		if (x_odd && !rf[FRAC_BITS-1])
			dy = -2'sd1;
		if (yinc)
			dy = dy + 2'sd1;
		if (ydec)
			dy = dy - 2'sd1;
	end

	assign x_adj = cx + {{(IPW-1){1'b0}}, step};
	assign y_adj = ry + {{(IPW-2){dy[1]}}, dy};

	assign col = sat(x_adj);
	assign row = sat(y_adj);

endmodule

`default_nettype wire
